/* hdl/eeprom_page_write_sequencer_defines.svh */
// Assertion macros for the EEPROM page write sequencer.
// Used by the top level; each macro expects clk_i and rst_ni in scope.
`ifndef EEPROM_PAGE_WRITE_SEQUENCER_DEFINES_SVH
`define EEPROM_PAGE_WRITE_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPWS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("EPWS same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EPWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("EPWS next-cycle check failed");

`endif

/* hdl/epws_pkg.sv */
// Package of the EEPROM page write sequencer: codes, widths and payload types.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package epws_pkg;

  // Page geometry of the device.
  localparam int unsigned PageBytes = 64;
  localparam int unsigned PageAw    = $clog2(PageBytes);
  localparam int unsigned RoomW     = PageAw + 1;

  // Highest address that a write request may start at.
  localparam logic [15:0] MaxWriteAddr = 16'h7FFF;

  // Item commands.
  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdDone  = 2'd2;
  localparam logic [1:0] CmdTick  = 2'd3;

  // Bus transaction kinds.
  localparam logic [1:0] LaunchNone  = 2'd0;
  localparam logic [1:0] LaunchRead  = 2'd1;
  localparam logic [1:0] LaunchWrite = 2'd2;
  localparam logic [1:0] LaunchPoll  = 2'd3;

  // Sequencer modes.
  localparam logic [2:0] ModeStopped = 3'd0;
  localparam logic [2:0] ModeReading = 3'd1;
  localparam logic [2:0] ModeWriting = 3'd2;
  localparam logic [2:0] ModeWaitAck = 3'd3;
  localparam logic [2:0] ModeFailed  = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [15:0] size;
    logic        has_callback;
    logic        trx_ok;
    logic        bus_accepts;
  } epws_cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  launch;
    logic [15:0] launch_address;
    logic [15:0] launch_length;
    logic [15:0] buffer_offset;
    logic        notify;
    logic [2:0]  mode_out;
  } epws_rsp_t;

endpackage

`default_nettype wire

/* hdl/epws_cmd_if.sv */
// Valid/ready channel that carries one command item per transfer.
// Depends on epws_pkg for the payload type.
`default_nettype none

interface epws_cmd_if;
  logic                 valid;
  logic                 ready;
  epws_pkg::epws_cmd_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/epws_rsp_if.sv */
// Valid/ready channel that carries one result item per transfer.
// Depends on epws_pkg for the payload type.
`default_nettype none

interface epws_rsp_if;
  logic                 valid;
  logic                 ready;
  epws_pkg::epws_rsp_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/epws_step.sv */
// Sequencer state and the combinational step logic for one command item.
// Depends on epws_pkg; instantiated by eeprom_page_write_sequencer.
`default_nettype none

module epws_step (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_en_i,
  input  wire epws_pkg::epws_cmd_t  item_i,
  output epws_pkg::epws_rsp_t       res_o
);

  logic [2:0]  mode_q, mode_d;
  logic [15:0] waddr_q, waddr_d;
  logic [15:0] left_q, left_d;
  logic [15:0] woff_q, woff_d;
  logic        armed_q, armed_d;

  logic        do_chunk;
  logic        chunk_ok;
  logic [15:0] src_addr;
  logic [15:0] src_left;
  logic [15:0] src_off;
  logic        src_armed;
  logic [epws_pkg::RoomW-1:0] room;
  logic [15:0] chunk_len;
  logic        is_write;

  // A write request starts the chunk from the request fields, a
  // completion in waiting-ack mode from the stored job.
  assign is_write  = (item_i.command == epws_pkg::CmdWrite);
  assign src_addr  = is_write ? item_i.address : waddr_q;
  assign src_left  = is_write ? item_i.size : left_q;
  assign src_off   = is_write ? 16'd0 : woff_q;
  assign src_armed = is_write ? item_i.has_callback : armed_q;

  // A chunk ends at the page boundary or with the job, whichever comes first.
  assign room = epws_pkg::RoomW'(epws_pkg::PageBytes)
              - epws_pkg::RoomW'(src_addr[epws_pkg::PageAw-1:0]);
  assign chunk_len = (src_left < 16'(room)) ? src_left : 16'(room);

  // Next state and result of the current item.
  always_comb begin
    mode_d   = mode_q;
    waddr_d  = waddr_q;
    left_d   = left_q;
    woff_d   = woff_q;
    armed_d  = armed_q;
    do_chunk = 1'b0;
    chunk_ok = 1'b0;
    res_o    = '0;

    unique case (item_i.command)
      epws_pkg::CmdRead: begin
        if (mode_q == epws_pkg::ModeStopped) begin
          armed_d              = item_i.has_callback;
          res_o.launch         = epws_pkg::LaunchRead;
          res_o.launch_address = item_i.address;
          res_o.launch_length  = item_i.size;
          if (item_i.bus_accepts) begin
            res_o.accepted = 1'b1;
            mode_d         = epws_pkg::ModeReading;
          end
        end
      end
      epws_pkg::CmdWrite: begin
        if (mode_q == epws_pkg::ModeStopped && item_i.address <= epws_pkg::MaxWriteAddr) begin
          waddr_d  = item_i.address;
          left_d   = item_i.size;
          woff_d   = '0;
          armed_d  = item_i.has_callback;
          do_chunk = 1'b1;
        end
      end
      epws_pkg::CmdDone: begin
        if (!item_i.trx_ok) begin
          if (mode_q != epws_pkg::ModeWaitAck) begin
            mode_d       = epws_pkg::ModeFailed;
            res_o.notify = armed_q;
            armed_d      = 1'b0;
          end
        end else begin
          case (mode_q)
            epws_pkg::ModeReading: begin
              res_o.notify = armed_q;
              armed_d      = 1'b0;
              mode_d       = epws_pkg::ModeStopped;
            end
            epws_pkg::ModeWriting: mode_d = epws_pkg::ModeWaitAck;
            epws_pkg::ModeWaitAck: do_chunk = 1'b1;
            epws_pkg::ModeFailed:  mode_d = epws_pkg::ModeStopped;
            default:               mode_d = epws_pkg::ModeFailed;
          endcase
        end
      end
      default: begin
        if (mode_q == epws_pkg::ModeWaitAck || mode_q == epws_pkg::ModeFailed) begin
          res_o.launch = epws_pkg::LaunchPoll;
        end
      end
    endcase

    // Issue the next page chunk, or finish when nothing is left.
    if (do_chunk) begin
      if (src_left == 16'd0) begin
        mode_d       = epws_pkg::ModeStopped;
        res_o.notify = src_armed;
        armed_d      = 1'b0;
        chunk_ok     = 1'b1;
      end else begin
        res_o.launch         = epws_pkg::LaunchWrite;
        res_o.launch_address = src_addr;
        res_o.launch_length  = chunk_len;
        res_o.buffer_offset  = src_off;
        if (item_i.bus_accepts) begin
          mode_d   = epws_pkg::ModeWriting;
          left_d   = src_left - chunk_len;
          waddr_d  = src_addr + chunk_len;
          woff_d   = src_off + chunk_len;
          chunk_ok = 1'b1;
        end else begin
          mode_d = epws_pkg::ModeFailed;
        end
      end
    end

    if (is_write) begin
      res_o.accepted = chunk_ok;
    end
    res_o.mode_out = mode_d;
  end

  // State registers advance once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= epws_pkg::ModeStopped;
      waddr_q <= '0;
      left_q  <= '0;
      woff_q  <= '0;
      armed_q <= 1'b0;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      waddr_q <= waddr_d;
      left_q  <= left_d;
      woff_q  <= woff_d;
      armed_q <= armed_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/eeprom_page_write_sequencer.sv */
// EEPROM page write sequencer: how to use it.
// cmd_i takes one item per transfer: a read request, a write request, a bus
// completion or a service tick, with the bus acceptance flag for any
// transaction launched by that item. rsp_o gives exactly one result per
// item: request status, the launched transaction (read, page write chunk or
// acknowledge poll) with its address, length and buffer offset, the caller
// notification and the mode after the item.
// A cmd_i item first lands in the input register; the step logic then
// writes the result register and updates the sequencer state in the same
// edge. One item is stepped per cycle while rsp_o takes results; the
// single step stage is the only path that sets this rate. cmd_i stays
// ready while the input register is empty or moves on, so an item is
// taken while a finished result waits.
// When rsp_o stalls, the result register holds, the input register holds
// its item and cmd_i drops ready once both are full; nothing is lost.
// Reset clears the mode to stopped, the job counters, the pending
// notification and both valid flags; the block is usable right after reset.
`default_nettype none
`include "eeprom_page_write_sequencer_defines.svh"

module eeprom_page_write_sequencer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  epws_cmd_if.sink   cmd_i,
  epws_rsp_if.source rsp_o
);

  logic                 in_valid_q;
  epws_pkg::epws_cmd_t  in_item_q;
  logic                 out_valid_q;
  epws_pkg::epws_rsp_t  out_item_q;
  epws_pkg::epws_rsp_t  step_res;
  logic                 advance;
  logic [16:0]          chunk_end;

  // The step stage fires when it holds an item and the result slot frees up.
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_item_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      in_item_q <= cmd_i.payload;
    end
  end

  // Step logic and sequencer state.
  epws_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .res_o     (step_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= step_res;
    end
  end

  // End of a page write chunk relative to its page start.
  assign chunk_end = 17'(out_item_q.launch_address[epws_pkg::PageAw-1:0])
                   + 17'(out_item_q.launch_length);

  // A page write chunk is never empty and never crosses a page.
  `EPWS_ASSERT_SAME(a_chunk_in_page, out_valid_q && out_item_q.launch == epws_pkg::LaunchWrite, out_item_q.launch_length != 16'd0 && chunk_end <= 17'(epws_pkg::PageBytes))
  // A notification only fires when the job has ended.
  `EPWS_ASSERT_SAME(a_notify_at_end, out_valid_q && out_item_q.notify, out_item_q.mode_out == epws_pkg::ModeStopped || out_item_q.mode_out == epws_pkg::ModeFailed)
  // Every step produces a result in the next cycle.
  `EPWS_ASSERT_NEXT(a_step_gives_result, advance, out_valid_q)
  // An accepted write that launched a chunk always leaves the mode at writing.
  `EPWS_ASSERT_SAME(a_write_accept_mode, out_valid_q && out_item_q.accepted && out_item_q.launch == epws_pkg::LaunchWrite, out_item_q.mode_out == epws_pkg::ModeWriting)

endmodule

`default_nettype wire
